// File: hdl/srb_pkg.sv
// package for the bitmap shape rasterizer: function codes, widths, command struct
// used by srb_ctrl, srb_datapath and shape_rasterizer_bitmap
package srb_pkg;
  localparam int CanvasWidthDef  = 64;
  localparam int CanvasHeightDef = 32;
  localparam int RowBitsW        = 64;
  // stepping registers: coordinates, deltas and error terms fit in 12 bits
  localparam int StepW           = 12;

  localparam logic [2:0] FUNC_LINE   = 3'd0;
  localparam logic [2:0] FUNC_RECT   = 3'd1;
  localparam logic [2:0] FUNC_TRI    = 3'd2;
  localparam logic [2:0] FUNC_CIRCLE = 3'd3;
  localparam logic [2:0] FUNC_CLEAR  = 3'd4;
  localparam logic [2:0] FUNC_READ   = 3'd5;

  // datapath commands from the controller
  typedef struct packed {
    logic       load;      // capture the input item
    logic [1:0] seg_sel;   // which segment of the shape to set up
    logic       seg_init;  // set up bresenham for seg_sel
    logic       seg_step;  // plot current point and advance
    logic       circ_init;
    logic       circ_step; // plot one of eight octant points
    logic       clr_step;  // write zero to clear row
    logic       rd_issue;  // read the selected row
    logic       px_issue;  // not driven or used; the pending pixel's row is the default ram address
    logic       px_write;  // write back the row with pixel set
    logic       out_load;  // load result register
  } srb_cmd_t;

  typedef struct packed {
    logic [2:0] func;
    logic       seg_done;  // current point is the end point
    logic       circ_done; // circle loop has ended
    logic       oct_last;  // eighth point of the current step
    logic       clr_last;
    logic       px_valid;  // pending point is on the canvas
  } srb_sts_t;
endpackage

// File: hdl/srb_ram.sv
// generic single-port ram with registered read
// no dependencies
module srb_ram #(
  parameter int Width = 64,
  parameter int Depth = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// File: hdl/srb_datapath.sv
// datapath: bresenham line and circle stepping, pixel clip, canvas row ram, result register
// depends on srb_pkg and srb_ram
module srb_datapath
  import srb_pkg::*;
#(
  parameter int CanvasWidth  = CanvasWidthDef,
  parameter int CanvasHeight = CanvasHeightDef
) (
  input  logic            clk,
  input  logic            rst_n,
  input  srb_cmd_t        cmd,
  output srb_sts_t        sts,
  input  logic [2:0]      in_func,
  input  logic [47:0]     in_pts,
  input  logic [6:0]      in_radius,
  input  logic [4:0]      in_row_sel,
  output logic [RowBitsW-1:0] res_bits,
  output logic            res_read
);
  localparam int AddrW = $clog2(CanvasHeight);
  typedef logic signed [StepW-1:0] s_t;

  logic [2:0]  func_r;
  s_t ax_r, ay_r, bx_r, by_r, cx_r, cy_r;
  logic [6:0]  rad_r;
  logic [4:0]  row_r;
  // segment state
  s_t px_r, py_r, ex_r, ey_r, dx_r, dy_r, err_r;
  logic stx_r, sty_r;
  // circle state
  s_t u_r, v_r, d_r;
  logic [2:0] oct_r;
  // pending pixel
  s_t qx_r, qy_r;
  logic [AddrW:0] clr_r;
  logic [RowBitsW-1:0] res_bits_r;
  logic res_read_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      func_r <= '0;
    end else if (cmd.load) begin
      func_r <= in_func;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ax_r <= StepW'($signed(in_pts[7:0]));
      ay_r <= StepW'($signed(in_pts[15:8]));
      bx_r <= StepW'($signed(in_pts[23:16]));
      by_r <= StepW'($signed(in_pts[31:24]));
      cx_r <= StepW'($signed(in_pts[39:32]));
      cy_r <= StepW'($signed(in_pts[47:40]));
      rad_r <= in_radius;
      row_r <= in_row_sel;
    end
  end

  // segment endpoints per shape and segment index
  s_t sax, say, sbx, sby;
  always_comb begin
    sax = ax_r; say = ay_r; sbx = bx_r; sby = by_r;
    case (func_r)
      FUNC_RECT: begin
        case (cmd.seg_sel)
          2'd0: begin sax = ax_r; say = ay_r; sbx = bx_r; sby = ay_r; end
          2'd1: begin sax = ax_r; say = by_r; sbx = bx_r; sby = by_r; end
          2'd2: begin sax = ax_r; say = ay_r; sbx = ax_r; sby = by_r; end
          default: begin sax = bx_r; say = ay_r; sbx = bx_r; sby = by_r; end
        endcase
      end
      FUNC_TRI: begin
        case (cmd.seg_sel)
          2'd0: begin sax = ax_r; say = ay_r; sbx = bx_r; sby = by_r; end
          2'd1: begin sax = bx_r; say = by_r; sbx = cx_r; sby = cy_r; end
          default: begin sax = cx_r; say = cy_r; sbx = ax_r; sby = ay_r; end
        endcase
      end
      default: ;
    endcase
  end

  s_t e2, adx, ady;
  assign e2  = err_r <<< 1;
  assign adx = (sbx > sax) ? sbx - sax : sax - sbx;
  assign ady = (sby > say) ? sby - say : say - sby;

  // octant point of the circle
  s_t ox, oy;
  always_comb begin
    case (oct_r)
      3'd0: begin ox = ax_r + u_r; oy = ay_r + v_r; end
      3'd1: begin ox = ax_r - u_r; oy = ay_r + v_r; end
      3'd2: begin ox = ax_r + u_r; oy = ay_r - v_r; end
      3'd3: begin ox = ax_r - u_r; oy = ay_r - v_r; end
      3'd4: begin ox = ax_r + v_r; oy = ay_r + u_r; end
      3'd5: begin ox = ax_r - v_r; oy = ay_r + u_r; end
      3'd6: begin ox = ax_r + v_r; oy = ay_r - u_r; end
      default: begin ox = ax_r - v_r; oy = ay_r - u_r; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.seg_init) begin
      px_r <= sax; py_r <= say; ex_r <= sbx; ey_r <= sby;
      dx_r <= adx; dy_r <= -ady; err_r <= adx - ady;
      stx_r <= (sax < sbx); sty_r <= (say < sby);
    end else if (cmd.seg_step) begin
      qx_r <= px_r; qy_r <= py_r;
      if (e2 >= dy_r && e2 <= dx_r) begin
        err_r <= err_r + dy_r + dx_r;
      end else if (e2 >= dy_r) begin
        err_r <= err_r + dy_r;
      end else if (e2 <= dx_r) begin
        err_r <= err_r + dx_r;
      end
      if (e2 >= dy_r) px_r <= stx_r ? px_r + s_t'(1) : px_r - s_t'(1);
      if (e2 <= dx_r) py_r <= sty_r ? py_r + s_t'(1) : py_r - s_t'(1);
    end
    if (cmd.circ_init) begin
      u_r <= '0;
      v_r <= s_t'(rad_r);
      d_r <= s_t'(3) - (s_t'(rad_r) <<< 1);
      oct_r <= '0;
    end else if (cmd.circ_step) begin
      qx_r <= ox; qy_r <= oy;
      oct_r <= oct_r + 3'd1;
      if (oct_r == 3'd7) begin
        u_r <= u_r + s_t'(1);
        if (d_r > 0) begin
          v_r <= v_r - s_t'(1);
          d_r <= d_r + ((u_r + s_t'(1) - (v_r - s_t'(1))) <<< 2) + s_t'(10);
        end else begin
          d_r <= d_r + ((u_r + s_t'(1)) <<< 2) + s_t'(6);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else if (cmd.load) begin
      clr_r <= '0;
    end else if (cmd.clr_step) begin
      clr_r <= clr_r + 1'b1;
    end
  end

  logic q_ok;
  assign q_ok = (qx_r >= 0) && (qx_r < CanvasWidth) && (qy_r >= 0) && (qy_r < CanvasHeight);

  logic we;
  logic [AddrW-1:0] addr;
  logic [RowBitsW-1:0] wdata, rdata;
  always_comb begin
    we = 1'b0;
    addr = qy_r[AddrW-1:0];
    wdata = rdata | (RowBitsW'(1) << qx_r[5:0]);
    if (cmd.clr_step) begin
      we = 1'b1; addr = clr_r[AddrW-1:0]; wdata = '0;
    end else if (cmd.rd_issue) begin
      addr = AddrW'(row_r);
    end else if (cmd.px_write) begin
      we = 1'b1;
    end
  end

  srb_ram #(.Width(RowBitsW), .Depth(CanvasHeight)) u_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      res_read_r <= (func_r == FUNC_READ);
      res_bits_r <= (func_r == FUNC_READ && 32'(row_r) < CanvasHeight) ? rdata : '0;
    end
  end

  assign res_bits = res_bits_r;
  assign res_read = res_read_r;

  assign sts.func      = func_r;
  assign sts.seg_done  = (px_r == ex_r) && (py_r == ey_r);
  assign sts.circ_done = (v_r < u_r);
  assign sts.oct_last  = (oct_r == 3'd7);
  assign sts.clr_last  = (clr_r == (AddrW+1)'(CanvasHeight - 1));
  assign sts.px_valid  = q_ok;
endmodule

// File: hdl/srb_ctrl.sv
// controller fsm: sequences segments, circle octants, pixel read-modify-write and output
// depends on srb_pkg
module srb_ctrl
  import srb_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_fire,
  input  logic     out_busy,
  input  srb_sts_t sts,
  output srb_cmd_t cmd,
  output logic     idle,
  output logic     out_set
);
  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_DISP  = 10'b0000000010,
    S_SINIT = 10'b0000000100,
    S_SSTEP = 10'b0000001000,
    S_CINIT = 10'b0000010000,
    S_CSTEP = 10'b0000100000,
    S_PXRD  = 10'b0001000000,
    S_PXWR  = 10'b0010000000,
    S_CLR   = 10'b0100000000,
    S_RDWT  = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;
  logic [1:0] seg_r, seg_nxt;
  logic last_r, last_nxt; // pending pixel is the final one of its segment
  logic circ_r, circ_nxt;
  logic rdv_r, rdv_nxt;   // read data of the row read is valid next cycle
  // the clear pass after reset gives no result; a clear command gives one
  logic clr_cmd_r;

  logic [1:0] seg_max;
  assign seg_max = (sts.func == FUNC_RECT) ? 2'd3 : (sts.func == FUNC_TRI) ? 2'd2 : 2'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR; seg_r <= '0; last_r <= 1'b0; circ_r <= 1'b0; rdv_r <= 1'b0;
    end else begin
      state_r <= state_nxt; seg_r <= seg_nxt; last_r <= last_nxt;
      circ_r <= circ_nxt; rdv_r <= rdv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cmd_r <= 1'b0;
    end else if (cmd.load) begin
      clr_cmd_r <= 1'b1;
    end
  end

  always_comb begin
    cmd = '0;
    cmd.seg_sel = seg_r;
    state_nxt = state_r; seg_nxt = seg_r; last_nxt = last_r;
    circ_nxt = circ_r; rdv_nxt = 1'b0;
    out_set = 1'b0;
    idle = (state_r == S_IDLE) && !out_busy;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cmd.load = 1'b1;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        seg_nxt = '0;
        case (sts.func)
          FUNC_LINE, FUNC_RECT, FUNC_TRI: begin
            circ_nxt = 1'b0; state_nxt = S_SINIT;
          end
          FUNC_CIRCLE: begin
            circ_nxt = 1'b1; state_nxt = S_CINIT;
          end
          FUNC_CLEAR: state_nxt = S_CLR;
          FUNC_READ: begin
            cmd.rd_issue = 1'b1; state_nxt = S_RDWT;
          end
          default: begin
            cmd.out_load = 1'b1; out_set = 1'b1; state_nxt = S_IDLE;
          end
        endcase
      end
      S_SINIT: begin
        cmd.seg_init = 1'b1; state_nxt = S_SSTEP;
      end
      S_SSTEP: begin
        cmd.seg_step = 1'b1;
        last_nxt = sts.seg_done;
        state_nxt = S_PXRD;
      end
      S_CINIT: begin
        cmd.circ_init = 1'b1; state_nxt = S_CSTEP;
      end
      S_CSTEP: begin
        if (sts.circ_done) begin
          cmd.out_load = 1'b1; out_set = 1'b1; state_nxt = S_IDLE;
        end else begin
          cmd.circ_step = 1'b1; last_nxt = 1'b0; state_nxt = S_PXRD;
        end
      end
      S_PXRD: begin
        // address is the pending row; data arrives next cycle
        state_nxt = S_PXWR;
      end
      S_PXWR: begin
        cmd.px_write = sts.px_valid;
        if (circ_r) begin
          state_nxt = S_CSTEP;
        end else if (!last_r) begin
          state_nxt = S_SSTEP;
        end else if (seg_r != seg_max) begin
          seg_nxt = seg_r + 2'd1; state_nxt = S_SINIT;
        end else begin
          state_nxt = S_IDLE;
        end
        if (!circ_r && last_r && seg_r == seg_max) begin
          cmd.out_load = 1'b1; out_set = 1'b1;
        end
      end
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
          out_set = clr_cmd_r;
          cmd.out_load = clr_cmd_r;
        end
      end
      S_RDWT: begin
        cmd.rd_issue = 1'b1;
        rdv_nxt = 1'b1;
        if (rdv_r) begin
          cmd.out_load = 1'b1; out_set = 1'b1; state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end
endmodule

// File: hdl/shape_rasterizer_bitmap.sv
// top level of the bitmap shape rasterizer
// depends on srb_pkg, srb_ctrl, srb_datapath, srb_ram
//
// One command at a time. Each plotted point is a step, a row read and a row
// write through the single port of the canvas row ram. A circle plots eight
// octant points per bresenham step. The next item can be accepted in the cycle
// its predecessor's result transfers. After reset a clearing pass over every
// canvas row runs before the first item is accepted. Every command returns
// exactly one result.
module shape_rasterizer_bitmap
  import srb_pkg::*;
#(
  parameter int CANVAS_WIDTH  = CanvasWidthDef,
  parameter int CANVAS_HEIGHT = CanvasHeightDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // func, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y, radius, row_sel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // row_bits[63:0]
  output logic        out_tuser   // is_read
);
  srb_cmd_t cmd;
  srb_sts_t sts;
  logic idle, out_set, out_valid_r;
  logic [RowBitsW-1:0] res_bits;
  logic res_read;

  assign in_tready = idle;

  srb_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_tvalid && in_tready),
    .out_busy(out_valid_r && !out_tready),
    .sts(sts), .cmd(cmd), .idle(idle), .out_set(out_set)
  );

  srb_datapath #(.CanvasWidth(CANVAS_WIDTH), .CanvasHeight(CANVAS_HEIGHT)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_func(in_tdata[2:0]), .in_pts(in_tdata[50:3]),
    .in_radius(in_tdata[57:51]), .in_row_sel(in_tdata[62:58]),
    .res_bits(res_bits), .res_read(res_read)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_set) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = res_bits;
  assign out_tuser  = res_read;

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |-> !out_valid_r || out_tready)
    else $error("item accepted while result stalled");
  a_read_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == '0)
    else $error("nonzero row bits on non-read result");
endmodule
